[hdl/xcps_pkg.sv]
package xcps_pkg;

  // Packet geometry.
  localparam int BlockBytes = 128;
  localparam int AddrW      = $clog2(BlockBytes);
  localparam int FillW      = $clog2(BlockBytes + 1);
  localparam int IdxW       = $clog2(BlockBytes + 6);

  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Protocol characters.
  localparam logic [7:0] ChSoh   = 8'h01;
  localparam logic [7:0] ChEot   = 8'h04;
  localparam logic [7:0] ChAck   = 8'h06;
  localparam logic [7:0] ChNak   = 8'h15;
  localparam logic [7:0] ChEtb   = 8'h17;
  localparam logic [7:0] ChStart = 8'h43;

  // CRC-16 polynomial.
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Kind of an incoming item.
  typedef enum logic [1:0] {
    KIND_RX      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_SLOT    = 2'd3
  } kind_e;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       is_start;
    logic       is_ack;
    logic       is_nak;
  } item_t;

endpackage

[hdl/xcps_front.sv]
module xcps_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     func_i,
  input  logic [7:0]     data_byte_i,
  output logic           item_valid_o,
  input  logic           item_pop_i,
  output xcps_pkg::item_t item_o
);
  import xcps_pkg::*;

  item_t             queue_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              push;
  logic              pop;
  item_t             item_in;

  // Classify the incoming item and pre-decode the reply characters.
  always_comb begin
    item_in.kind     = kind_e'(func_i);
    item_in.data     = data_byte_i;
    item_in.is_start = (data_byte_i == ChStart);
    item_in.is_ack   = (data_byte_i == ChAck);
    item_in.is_nak   = (data_byte_i == ChNak);
  end

  // Queue occupancy and pointers.
  assign in_ready_o   = (count_q != QCntW'(QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[hdl/xcps_back.sv]
module xcps_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  input  xcps_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            want_payload_o,
  output logic            finished_o,
  output logic [2:0]      phase_code_o
);
  import xcps_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT_C     = 3'd0,
    PH_LOAD       = 3'd1,
    PH_SEND       = 3'd2,
    PH_WAIT_REPLY = 3'd3,
    PH_SEND_EOT   = 3'd4,
    PH_WAIT_EOT   = 3'd5,
    PH_ETB        = 3'd6,
    PH_DONE       = 3'd7
  } phase_e;

  localparam logic [IdxW-1:0] IdxBlk  = IdxW'(1);
  localparam logic [IdxW-1:0] IdxInv  = IdxW'(2);
  localparam logic [IdxW-1:0] IdxData = IdxW'(3);
  localparam logic [IdxW-1:0] IdxCrcH = IdxW'(BlockBytes + 3);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(BlockBytes + 5);

  phase_e            phase_q, phase_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        block_q, block_d;
  logic [15:0]       crc_q, crc_d;
  logic              end_seen_q, end_seen_d;
  logic              etb_stage_q, etb_stage_d;
  logic              out_valid_q, out_valid_d;
  logic              tx_valid_q, tx_valid_d;
  logic [7:0]        tx_byte_q, tx_byte_d;

  logic [7:0]        buffer_mem [BlockBytes];
  logic [7:0]        rd_data_q;
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   data_pos;
  logic [7:0]        data_byte;
  logic              fire;

  // CRC-16 update over one byte, most significant bit first.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // An item executes when the result register is free or being emptied.
  assign fire       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = fire;

  // Data byte at the current send position, zero past the end of the payload.
  assign data_pos  = idx_q - IdxData;
  assign data_byte = (data_pos < IdxW'(fill_q)) ? rd_data_q : 8'h00;

  // The buffer is read one step ahead, at the position the next slot will need.
  assign rd_addr = AddrW'(idx_d - IdxData);

  // Next-state logic for the sequencer.
  always_comb begin
    phase_d     = phase_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    block_d     = block_q;
    crc_d       = crc_q;
    end_seen_d  = end_seen_q;
    etb_stage_d = etb_stage_q;
    tx_valid_d  = 1'b0;
    tx_byte_d   = 8'h00;
    wr_en       = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PH_WAIT_C: begin
          if (item_i.kind == KIND_RX && item_i.is_start) begin
            phase_d = PH_LOAD;
            fill_d  = '0;
          end
        end
        PH_LOAD: begin
          if (item_i.kind == KIND_PAYLOAD) begin
            if (fill_q < FillW'(BlockBytes)) begin
              wr_en  = 1'b1;
              fill_d = fill_q + 1'b1;
            end
            if (fill_d >= FillW'(BlockBytes)) begin
              phase_d = PH_SEND;
              idx_d   = '0;
              crc_d   = '0;
            end
          end else if (item_i.kind == KIND_END) begin
            end_seen_d = 1'b1;
            if (fill_q == '0) begin
              phase_d = PH_SEND_EOT;
            end else begin
              phase_d = PH_SEND;
              idx_d   = '0;
              crc_d   = '0;
            end
          end
        end
        PH_SEND: begin
          if (item_i.kind == KIND_SLOT) begin
            tx_valid_d = 1'b1;
            if (idx_q == '0) begin
              tx_byte_d = ChSoh;
            end else if (idx_q == IdxBlk) begin
              tx_byte_d = block_q;
            end else if (idx_q == IdxInv) begin
              tx_byte_d = ~block_q;
            end else if (idx_q < IdxCrcH) begin
              tx_byte_d = data_byte;
              crc_d     = crc_add(crc_q, data_byte);
            end else if (idx_q == IdxCrcH) begin
              tx_byte_d = crc_q[15:8];
            end else begin
              tx_byte_d = crc_q[7:0];
            end
            idx_d = idx_q + 1'b1;
            if (idx_d >= IdxLast) begin
              phase_d = PH_WAIT_REPLY;
            end
          end
        end
        PH_WAIT_REPLY: begin
          if (item_i.kind == KIND_RX) begin
            if (item_i.is_ack) begin
              block_d = block_q + 1'b1;
              if (end_seen_q) begin
                phase_d = PH_SEND_EOT;
              end else begin
                phase_d = PH_LOAD;
                fill_d  = '0;
              end
            end else if (item_i.is_nak) begin
              phase_d = PH_SEND;
              idx_d   = '0;
              crc_d   = '0;
            end
          end
        end
        PH_SEND_EOT: begin
          if (item_i.kind == KIND_SLOT) begin
            tx_valid_d = 1'b1;
            tx_byte_d  = ChEot;
            phase_d    = PH_WAIT_EOT;
          end
        end
        PH_WAIT_EOT: begin
          if (item_i.kind == KIND_RX) begin
            if (item_i.is_ack) begin
              phase_d     = PH_ETB;
              etb_stage_d = 1'b0;
            end else if (item_i.is_nak) begin
              phase_d = PH_SEND_EOT;
            end
          end
        end
        PH_ETB: begin
          if (!etb_stage_q) begin
            if (item_i.kind == KIND_SLOT) begin
              tx_valid_d  = 1'b1;
              tx_byte_d   = ChEtb;
              etb_stage_d = 1'b1;
            end
          end else if (item_i.kind == KIND_RX) begin
            if (item_i.is_ack) begin
              phase_d = PH_DONE;
            end else if (item_i.is_nak) begin
              etb_stage_d = 1'b0;
            end
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_C;
      fill_q      <= '0;
      idx_q       <= '0;
      block_q     <= 8'h01;
      crc_q       <= '0;
      end_seen_q  <= 1'b0;
      etb_stage_q <= 1'b0;
      out_valid_q <= 1'b0;
      tx_valid_q  <= 1'b0;
      tx_byte_q   <= 8'h00;
    end else begin
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      block_q     <= block_d;
      crc_q       <= crc_d;
      end_seen_q  <= end_seen_d;
      etb_stage_q <= etb_stage_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        tx_valid_q <= tx_valid_d;
        tx_byte_q  <= tx_byte_d;
      end
    end
  end

  // Payload buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buffer_mem[fill_q[AddrW-1:0]] <= item_i.data;
    end
    rd_data_q <= buffer_mem[rd_addr];
  end

  // The status fields follow the phase, which only moves when a result is made.
  assign out_valid_o    = out_valid_q;
  assign tx_valid_o     = tx_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign want_payload_o = (phase_q == PH_LOAD);
  assign finished_o     = (phase_q == PH_DONE);
  assign phase_code_o   = phase_q;

endmodule

[hdl/xmodem_crc_packet_sender_core.sv]
// XMODEM-CRC packet sender. Each input item is one of: a byte from the
// receiver, a payload byte, an end-of-payload mark or a free transmit slot,
// and each item yields exactly one result item carrying the byte sent (if
// any) and the current phase. The block sustains one item per clock cycle
// while the output is not stalled; every item is written into a two-entry
// queue and then executed by the sequencer, which registers its result
// item. The 128-byte payload buffer is a single-port-write, registered-read
// memory that is pre-read one slot ahead; it needs no clearing after reset,
// and the block accepts items as soon as reset is released.
module xmodem_crc_packet_sender_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       want_payload_o,
  output logic       finished_o,
  output logic [2:0] phase_code_o
);
  import xcps_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // Front: accept, classify and queue items.
  xcps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  // Back: run the protocol sequencer and hold the result.
  xcps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_pop_o     (item_pop),
    .item_i         (item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .want_payload_o (want_payload_o),
    .finished_o     (finished_o),
    .phase_code_o   (phase_code_o)
  );

endmodule
